>>> hdl/dfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

    // Parser limits, in bytes; LEN_W is the length field width in bits
    localparam int PEEK_MIN     = 12;
    localparam int SCAN_SPAN    = 6;
    localparam int FRAME_MIN    = 24;
    localparam int HEADER_BYTES = 20;
    localparam int MAGIC_BYTES  = 4;
    localparam int LEN_OFFSET   = 4;
    localparam int HDR_OFFSET   = 6;
    localparam int HDR_FETCH    = HEADER_BYTES - HDR_OFFSET;
    localparam int LEN_W        = 16;

    // Receive queue between front and back
    localparam int RXQ_DEPTH = 4;
    localparam int RXQ_AW    = 2;

    typedef enum logic [0:0] {
        CFG_START_MAGIC = 1'b0,
        CFG_END_MAGIC   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] start_magic;
        logic [31:0] end_magic;
    } t_dfr_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rxq_word;

    typedef struct packed {
        logic [15:0] version;
        logic [31:0] msg_id;
        logic [15:0] frame_index;
        logic [15:0] total_frames;
        logic [31:0] msg_type;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        last;
    } t_dfr_result;

endpackage

`default_nettype wire

>>> hdl/dfr_rx_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dfr_rx_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_data,
    output dfr_pkg::t_rxq_word     o_word,
    input  wire logic              i_pop
);

    logic [7:0]                  r_mem [dfr_pkg::RXQ_DEPTH];
    logic [dfr_pkg::RXQ_AW-1:0]  r_wr_ptr;
    logic [dfr_pkg::RXQ_AW-1:0]  r_rd_ptr;
    logic [dfr_pkg::RXQ_AW:0]    r_count;
    logic                        push;
    logic                        pop;

    assign o_stall      = (r_count == (dfr_pkg::RXQ_AW+1)'(dfr_pkg::RXQ_DEPTH));
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && (r_count != '0);
    assign o_word.valid = (r_count != '0);
    assign o_word.data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (dfr_pkg::RXQ_AW+1)'(dfr_pkg::RXQ_DEPTH))
        else $error("rx queue count past depth");

endmodule

`default_nettype wire

>>> hdl/dfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module dfr_parser #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dfr_pkg::t_dfr_cfg i_cfg,
    input  wire dfr_pkg::t_rxq_word i_rxq,
    output logic                   o_pop,
    output dfr_pkg::t_dfr_result   o_res,
    output logic                   o_res_valid,
    input  wire logic              i_res_stall
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int WIN_W = 8 * dfr_pkg::HDR_FETCH;
    localparam logic [AW:0] DEPTH_X = (AW+1)'(RING_DEPTH);
    localparam logic [dfr_pkg::LEN_W-1:0] DEPTH_L = dfr_pkg::LEN_W'(RING_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_EVAL_SCAN,
        ST_EVAL_END,
        ST_PAY_RD,
        ST_PAY_WAIT
    } t_state;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_END,
        PH_HDR
    } t_phase;

    function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] sum);
        logic [AW:0] d;
        if (sum >= DEPTH_X) begin
            d = sum - DEPTH_X;
        end else begin
            d = sum;
        end
        return d[AW-1:0];
    endfunction

    logic [7:0]           r_ring [RING_DEPTH];
    logic [7:0]           r_rd_data;

    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [AW-1:0]        r_rp, n_rp;
    logic [CW-1:0]        r_fill, n_fill;
    logic [AW-1:0]        r_off, n_off;
    logic [3:0]           r_iss_left, n_iss_left;
    logic [3:0]           r_cap_left, n_cap_left;
    logic                 r_rd_vld, n_rd_vld;
    logic [WIN_W-1:0]     r_win, n_win;
    logic [CW-1:0]        r_len, n_len;
    logic [AW-1:0]        r_pay_j, n_pay_j;
    logic                 r_out_vld, n_out_vld;
    dfr_pkg::t_dfr_result r_out, n_out;

    logic                 rd_en;
    logic [AW-1:0]        rd_off;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 drop_en;
    logic [AW:0]          drop_n;
    logic                 load;
    logic                 out_free;
    logic [2:0]           scan_pos;
    logic [dfr_pkg::LEN_W-1:0] len;
    logic [CW-1:0]        plen;
    logic [CW-1:0]        j_inc;

    assign rd_addr  = wrap_addr({1'b0, r_rp} + {1'b0, rd_off});
    assign wr_addr  = wrap_addr({1'b0, r_rp} + {1'b0, r_fill[AW-1:0]});
    assign out_free = !r_out_vld || !i_res_stall;
    assign len      = r_win[WIN_W-1 -: dfr_pkg::LEN_W];
    assign plen     = r_len - CW'(dfr_pkg::FRAME_MIN);
    assign j_inc    = CW'(r_pay_j) + CW'(1);

    // Head window: byte k of the head sits at r_win[WIN_W-48 + 8k]
    always_comb begin
        scan_pos = 3'(dfr_pkg::SCAN_SPAN);
        for (int k = dfr_pkg::SCAN_SPAN - 1; k >= 0; k--) begin
            if (r_win[WIN_W - 48 + 8*k +: 8] == i_cfg.start_magic[7:0]) begin
                scan_pos = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= i_rxq.data;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_rp       = r_rp;
        n_fill     = r_fill;
        n_off      = r_off;
        n_iss_left = r_iss_left;
        n_cap_left = r_cap_left;
        n_win      = r_win;
        n_len      = r_len;
        n_pay_j    = r_pay_j;
        n_out      = r_out;
        rd_en      = 1'b0;
        rd_off     = r_off;
        wr_en      = 1'b0;
        o_pop      = 1'b0;
        drop_en    = 1'b0;
        drop_n     = '0;
        load       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_rxq.valid) begin
                    o_pop = 1'b1;
                    // full ring: word is discarded, parser still runs
                    if (r_fill != CW'(RING_DEPTH)) begin
                        wr_en  = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_fill < CW'(dfr_pkg::PEEK_MIN)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state    = ST_FETCH;
                    n_phase    = PH_SCAN;
                    n_off      = '0;
                    n_iss_left = 4'(dfr_pkg::SCAN_SPAN);
                    n_cap_left = 4'(dfr_pkg::SCAN_SPAN);
                end
            end
            ST_FETCH: begin
                if (r_iss_left != '0) begin
                    rd_en      = 1'b1;
                    n_off      = r_off + 1'b1;
                    n_iss_left = r_iss_left - 1'b1;
                end
                if (r_rd_vld) begin
                    n_win      = {r_rd_data, r_win[WIN_W-1:8]};
                    n_cap_left = r_cap_left - 1'b1;
                    if (r_cap_left == 4'd1) begin
                        unique case (r_phase)
                            PH_SCAN: n_state = ST_EVAL_SCAN;
                            PH_END:  n_state = ST_EVAL_END;
                            PH_HDR: begin
                                n_state = ST_PAY_RD;
                                n_pay_j = '0;
                            end
                            default: n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_EVAL_SCAN: begin
                priority if (scan_pos != 3'd0) begin
                    drop_en = 1'b1;
                    drop_n  = (AW+1)'(scan_pos);
                    n_state = ST_CHECK;
                end else if (r_win[WIN_W-17 -: 32] != i_cfg.start_magic) begin
                    drop_en = 1'b1;
                    drop_n  = (AW+1)'(1);
                    n_state = ST_CHECK;
                end else if (len < dfr_pkg::LEN_W'(dfr_pkg::FRAME_MIN) || len > DEPTH_L) begin
                    drop_en = 1'b1;
                    drop_n  = (AW+1)'(1);
                    n_state = ST_CHECK;
                end else if (dfr_pkg::LEN_W'(r_fill) < len) begin
                    n_state = ST_IDLE;
                end else begin
                    n_len      = CW'(len);
                    n_state    = ST_FETCH;
                    n_phase    = PH_END;
                    n_off      = AW'(len - dfr_pkg::LEN_W'(dfr_pkg::MAGIC_BYTES));
                    n_iss_left = 4'(dfr_pkg::MAGIC_BYTES);
                    n_cap_left = 4'(dfr_pkg::MAGIC_BYTES);
                end
            end
            ST_EVAL_END: begin
                if (r_win[WIN_W-1 -: 32] != i_cfg.end_magic) begin
                    drop_en = 1'b1;
                    drop_n  = (AW+1)'(dfr_pkg::MAGIC_BYTES);
                    n_state = ST_CHECK;
                end else begin
                    n_state    = ST_FETCH;
                    n_phase    = PH_HDR;
                    n_off      = AW'(dfr_pkg::HDR_OFFSET);
                    n_iss_left = 4'(dfr_pkg::HDR_FETCH);
                    n_cap_left = 4'(dfr_pkg::HDR_FETCH);
                end
            end
            ST_PAY_RD: begin
                if (out_free) begin
                    if (plen == '0) begin
                        // empty payload: one marker word
                        load                = 1'b1;
                        n_out.payload_byte  = '0;
                        n_out.payload_valid = 1'b0;
                        n_out.last          = 1'b1;
                        drop_en             = 1'b1;
                        drop_n              = (AW+1)'(r_len);
                        n_state             = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_off  = AW'(dfr_pkg::HEADER_BYTES) + r_pay_j;
                        n_state = ST_PAY_WAIT;
                    end
                end
            end
            ST_PAY_WAIT: begin
                load                = 1'b1;
                n_out.payload_byte  = r_rd_data;
                n_out.payload_valid = 1'b1;
                n_out.last          = (j_inc == plen);
                n_pay_j             = r_pay_j + 1'b1;
                if (j_inc == plen) begin
                    drop_en = 1'b1;
                    drop_n  = (AW+1)'(r_len);
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PAY_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (load) begin
            n_out.version      = r_win[15:0];
            n_out.msg_id       = r_win[47:16];
            n_out.frame_index  = r_win[63:48];
            n_out.total_frames = r_win[79:64];
            n_out.msg_type     = r_win[111:80];
        end

        if (drop_en) begin
            n_rp   = wrap_addr({1'b0, r_rp} + drop_n);
            n_fill = r_fill - CW'(drop_n);
        end

        n_rd_vld = rd_en && (r_state == ST_FETCH);

        if (load) begin
            n_out_vld = 1'b1;
        end else if (!i_res_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win   <= n_win;
        r_len   <= n_len;
        r_pay_j <= n_pay_j;
        r_out   <= n_out;
        r_phase <= n_phase;
        r_off   <= n_off;
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rp       <= '0;
            r_fill     <= '0;
            r_iss_left <= '0;
            r_cap_left <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_fill     <= n_fill;
            r_iss_left <= n_iss_left;
            r_cap_left <= n_cap_left;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_vld;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(RING_DEPTH))
        else $error("ring fill past depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !(r_out_vld && i_res_stall))
        else $error("result register overwritten while held");

    a_scan_enough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL_SCAN) |-> (r_fill >= CW'(dfr_pkg::PEEK_MIN)))
        else $error("head evaluated with too few bytes");

endmodule

`default_nettype wire

>>> hdl/magic_framed_message_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Per word: queue pop and ring write, then fill check, while fewer than 12 bytes held.
// Each parser pass fetches the 6-byte head from the ring; a frame then fetches the 4-byte end
// marker and the 14-byte header, then for each result word a ring read and a result load.
// A 4-word input queue lets words arrive while the parser works or a result is held.
// Reset (synchronous, active low) clears queue, ring pointer, fill count and both markers;
// ring contents are left as they are and need no clearing pass.
module magic_framed_message_deframer #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_version,
    output logic [31:0]      o_msg_id,
    output logic [15:0]      o_frame_index,
    output logic [15:0]      o_total_frames,
    output logic [31:0]      o_msg_type,
    output logic [7:0]       o_payload_byte,
    output logic             o_payload_valid,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    dfr_pkg::t_dfr_cfg    r_cfg;
    dfr_pkg::t_rxq_word   rxq_word;
    dfr_pkg::t_dfr_result res;
    logic                 rxq_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (dfr_pkg::t_cfg_idx'(i_cfg_index))
                dfr_pkg::CFG_START_MAGIC: r_cfg.start_magic <= i_cfg_data;
                dfr_pkg::CFG_END_MAGIC:   r_cfg.end_magic   <= i_cfg_data;
                default:                  r_cfg             <= r_cfg;
            endcase
        end
    end

    dfr_rx_fifo u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_rx_byte),
        .o_word  (rxq_word),
        .i_pop   (rxq_pop)
    );

    dfr_parser #(
        .RING_DEPTH (RING_DEPTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rxq       (rxq_word),
        .o_pop       (rxq_pop),
        .o_res       (res),
        .o_res_valid (o_out_valid),
        .i_res_stall (i_out_stall)
    );

    assign o_version       = res.version;
    assign o_msg_id        = res.msg_id;
    assign o_frame_index   = res.frame_index;
    assign o_total_frames  = res.total_frames;
    assign o_msg_type      = res.msg_type;
    assign o_payload_byte  = res.payload_byte;
    assign o_payload_valid = res.payload_valid;
    assign o_last          = res.last;

endmodule

`default_nettype wire

>>> sim/magic_framed_message_deframer_tb.sv
`timescale 1ns / 1ps

module magic_framed_message_deframer_tb;

    localparam int RING_DEPTH    = 64;
    localparam int SETTLE_CYCLES = 3000;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 40;

    // Markers for the directed frame
    localparam logic [31:0] DIR_START = 32'hC3A5_965A;
    localparam logic [31:0] DIR_END   = 32'h0FF0_E11E;

    localparam int DIRECTED_ROWS   = 26;
    localparam int EMPTY_FRAME_ROW = DIRECTED_ROWS - 1;
    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_ROWS] = '{
        8'h00, 8'hFF,                   // junk ahead of the frame, scanned off
        8'h5A, 8'h96, 8'hA5, 8'hC3,     // start marker
        8'h18, 8'h00,                   // length 24: no payload
        8'hFF, 8'hFF,                   // version
        8'h00, 8'h00, 8'h00, 8'h00,     // msg_id
        8'h00, 8'h00,                   // frame_index
        8'hFF, 8'hFF,                   // total_frames
        8'hFF, 8'hFF, 8'hFF, 8'hFF,     // msg_type
        8'h1E, 8'hE1, 8'hF0, 8'h0F      // end marker
    };
    localparam dfr_pkg::t_dfr_result EMPTY_FRAME_WORD = '{
        version: 16'hFFFF, msg_id: 32'h0000_0000, frame_index: 16'h0000,
        total_frames: 16'hFFFF, msg_type: 32'hFFFF_FFFF,
        payload_byte: 8'h00, payload_valid: 1'b0, last: 1'b1
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_version;
    logic [31:0] o_msg_id;
    logic [15:0] o_frame_index;
    logic [15:0] o_total_frames;
    logic [31:0] o_msg_type;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // Shadow of the deframer
    logic [7:0]  rx_ring [RING_DEPTH];
    int          ring_head;
    int          ring_fill;
    logic [31:0] start_marker;
    logic [31:0] end_marker;
    dfr_pkg::t_dfr_result due_words [$];

    int send_idle_pct;
    int rcv_idle_pct = 0;
    logic hold_arm;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    int error_count = 0;
    int bytes_sent = 0;
    int words_checked = 0;
    int frames_checked = 0;
    int cycle_count = 0;

    magic_framed_message_deframer #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_version      (o_version),
        .o_msg_id       (o_msg_id),
        .o_frame_index  (o_frame_index),
        .o_total_frames (o_total_frames),
        .o_msg_type     (o_msg_type),
        .o_payload_byte (o_payload_byte),
        .o_payload_valid(o_payload_valid),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                     due_words.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic logic [7:0] ring_at(input int k);
        return rx_ring[(ring_head + k) % RING_DEPTH];
    endfunction

    function automatic logic [15:0] ring_le16(input int k);
        return {ring_at(k + 1), ring_at(k)};
    endfunction

    function automatic logic [31:0] ring_le32(input int k);
        return {ring_at(k + 3), ring_at(k + 2), ring_at(k + 1), ring_at(k)};
    endfunction

    function automatic void ring_drop(input int n);
        if (n > ring_fill)
            n = ring_fill;
        ring_head = (ring_head + n) % RING_DEPTH;
        ring_fill -= n;
    endfunction

    // Append one received byte, then resync until the parser stalls or a frame goes out
    function automatic void deframe_byte(input logic [7:0] b);
        int pos;
        int flen;
        int plen;
        dfr_pkg::t_dfr_result w;
        if (ring_fill < RING_DEPTH) begin
            rx_ring[(ring_head + ring_fill) % RING_DEPTH] = b;
            ring_fill++;
        end
        forever begin
            if (ring_fill < dfr_pkg::PEEK_MIN)
                break;
            pos = 0;
            while (pos < dfr_pkg::SCAN_SPAN && ring_at(pos) != start_marker[7:0])
                pos++;
            if (pos > 0) begin
                ring_drop(pos);
                continue;
            end
            if (ring_le32(0) != start_marker) begin
                ring_drop(1);
                continue;
            end
            flen = int'(ring_le16(dfr_pkg::LEN_OFFSET));
            if (flen < dfr_pkg::FRAME_MIN || flen > RING_DEPTH) begin
                ring_drop(1);
                continue;
            end
            if (ring_fill < flen)
                break;
            if (ring_le32(flen - dfr_pkg::MAGIC_BYTES) != end_marker) begin
                ring_drop(dfr_pkg::MAGIC_BYTES);
                continue;
            end
            w.version      = ring_le16(dfr_pkg::HDR_OFFSET);
            w.msg_id       = ring_le32(8);
            w.frame_index  = ring_le16(12);
            w.total_frames = ring_le16(14);
            w.msg_type     = ring_le32(16);
            plen = flen - dfr_pkg::FRAME_MIN;
            if (plen == 0) begin
                w.payload_byte  = 8'h00;
                w.payload_valid = 1'b0;
                w.last          = 1'b1;
                due_words.push_back(w);
            end else begin
                for (int j = 0; j < plen; j++) begin
                    w.payload_byte  = ring_at(dfr_pkg::HEADER_BYTES + j);
                    w.payload_valid = 1'b1;
                    w.last          = (j == plen - 1);
                    due_words.push_back(w);
                end
            end
            ring_drop(flen);
            break;
        end
    endfunction

    task automatic check_word();
        dfr_pkg::t_dfr_result want;
        if (due_words.size() == 0) begin
            flag_error("word with nothing due, msg_id", o_msg_id, 32'h0);
            return;
        end
        want = due_words.pop_front();
        if (o_version !== want.version)
            flag_error("version", 32'(o_version), 32'(want.version));
        if (o_msg_id !== want.msg_id)
            flag_error("msg_id", o_msg_id, want.msg_id);
        if (o_frame_index !== want.frame_index)
            flag_error("frame_index", 32'(o_frame_index), 32'(want.frame_index));
        if (o_total_frames !== want.total_frames)
            flag_error("total_frames", 32'(o_total_frames), 32'(want.total_frames));
        if (o_msg_type !== want.msg_type)
            flag_error("msg_type", o_msg_type, want.msg_type);
        if (o_payload_byte !== want.payload_byte)
            flag_error("payload_byte", 32'(o_payload_byte), 32'(want.payload_byte));
        if (o_payload_valid !== want.payload_valid)
            flag_error("payload_valid", 32'(o_payload_valid), 32'(want.payload_valid));
        if (o_last !== want.last)
            flag_error("last", 32'(o_last), 32'(want.last));
        words_checked++;
        if (want.last)
            frames_checked++;
    endtask

    // Result side: check, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            check_word();
        if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic cfg_write(input dfr_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            dfr_pkg::CFG_START_MAGIC: start_marker = val;
            dfr_pkg::CFG_END_MAGIC:   end_marker = val;
            default: ;
        endcase
    endtask

    task automatic set_markers(input logic [31:0] sm, input logic [31:0] em);
        cfg_write(dfr_pkg::CFG_START_MAGIC, sm);
        cfg_write(dfr_pkg::CFG_END_MAGIC, em);
        i_cfg_valid <= 1'b0;
    endtask

    // Valid stays high across back-to-back words; only lowered for a gap
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Mostly well-formed frames; the rest broken frames, noise and stray long headers
    task automatic send_random_traffic(input int n_bytes);
        int sent;
        int kind;
        int sel;
        int plen;
        int flen;
        logic [15:0] bad_len;
        logic [7:0] seq [$];
        sent = 0;
        while (sent < n_bytes) begin
            seq.delete();
            kind = $urandom_range(99);
            sel = $urandom_range(19);
            if (sel == 0)
                plen = RING_DEPTH - dfr_pkg::FRAME_MIN;
            else if (sel < 3)
                plen = $urandom_range(RING_DEPTH - dfr_pkg::FRAME_MIN - 1, 7);
            else
                plen = $urandom_range(6);
            flen = dfr_pkg::FRAME_MIN + plen;
            for (int k = 0; k < dfr_pkg::MAGIC_BYTES; k++)
                seq.push_back(start_marker[8*k +: 8]);
            seq.push_back(flen[7:0]);
            seq.push_back(flen[15:8]);
            for (int k = dfr_pkg::HDR_OFFSET; k < flen - dfr_pkg::MAGIC_BYTES; k++)
                seq.push_back(8'($urandom));
            for (int k = 0; k < dfr_pkg::MAGIC_BYTES; k++)
                seq.push_back(end_marker[8*k +: 8]);
            if (kind >= 60 && kind < 68) begin
                sel = $urandom_range(dfr_pkg::MAGIC_BYTES - 1);
                seq[sel] = seq[sel] ^ 8'($urandom_range(255, 1));
            end else if (kind >= 68 && kind < 76) begin
                if ($urandom_range(1))
                    bad_len = 16'($urandom_range(dfr_pkg::FRAME_MIN - 1));
                else
                    bad_len = 16'($urandom_range(65535, RING_DEPTH + 1));
                seq[dfr_pkg::LEN_OFFSET]     = bad_len[7:0];
                seq[dfr_pkg::LEN_OFFSET + 1] = bad_len[15:8];
            end else if (kind >= 76 && kind < 84) begin
                sel = flen - 1 - $urandom_range(dfr_pkg::MAGIC_BYTES - 1);
                seq[sel] = seq[sel] ^ 8'($urandom_range(255, 1));
            end else if (kind >= 84 && kind < 92) begin
                seq.delete();
                repeat ($urandom_range(8, 1))
                    seq.push_back(8'($urandom));
            end else if (kind >= 92) begin
                // header of a long frame that never ends; swallows what follows
                bad_len = 16'($urandom_range(RING_DEPTH, 40));
                seq = seq[0 : dfr_pkg::LEN_OFFSET - 1];
                seq.push_back(bad_len[7:0]);
                seq.push_back(bad_len[15:8]);
            end
            foreach (seq[k])
                push_byte(seq[k]);
            sent += seq.size();
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (due_words.size() != 0)
            @(posedge i_clk);
        // the parser may still be dropping bytes that yield nothing
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    initial begin
        int n_before;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = dfr_pkg::CFG_START_MAGIC;
        i_cfg_data  = 32'h0;
        hold_arm    = 1'b0;
        ring_head    = 0;
        ring_fill    = 0;
        start_marker = 32'h0;
        end_marker   = 32'h0;
        send_idle_pct = 26;
        rcv_idle_pct  = 57;
        repeat (7)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_markers(DIR_START, DIR_END);
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            n_before = due_words.size();
            push_byte(DIRECTED_BYTES[row]);
            if (row == EMPTY_FRAME_ROW) begin
                while (due_words.size() > n_before)
                    void'(due_words.pop_back());
                due_words.push_back(EMPTY_FRAME_WORD);
            end
        end
        i_in_valid <= 1'b0;
        wait_idle();

        set_markers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_random_traffic(85);
        wait_idle();

        send_idle_pct = 57;
        rcv_idle_pct <= 26;
        set_markers(32'h0000_0000, 32'h0000_0000);
        send_random_traffic(85);
        wait_idle();

        set_markers($urandom, $urandom);
        send_random_traffic(85);
        wait_idle();

        // no idling; receiver holds off long enough to back up the input
        send_idle_pct = 0;
        rcv_idle_pct <= 0;
        set_markers($urandom, DIR_END);
        hold_arm <= 1'b1;
        send_random_traffic(100);
        wait_idle();

        if (due_words.size() != 0)
            flag_error("words never delivered", 32'h0, 32'(due_words.size()));
        $display("Covered %0d received bytes over five marker settings and three idle mixes,",
                 bytes_sent);
        $display("checking %0d result words from %0d frames.", words_checked, frames_checked);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> magic_framed_message_deframer.f
hdl/dfr_pkg.sv
hdl/dfr_rx_fifo.sv
hdl/dfr_parser.sv
hdl/magic_framed_message_deframer.sv
sim/magic_framed_message_deframer_tb.sv
